>>> src/ptfr_pkg.sv
// Package for the paged translation block: field widths, opcode and status
// codes, request/result/entry types. No dependencies.
package ptfr_pkg;

  // Default geometry
  localparam int OFFSET_BITS    = 10;
  localparam int MAX_PAGES      = 64;
  localparam int RESIDENT_SLOTS = 3;
  localparam int FRAME_COUNT    = 64;
  localparam int DISK_BLOCKS    = 128;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 16;
  localparam int PNO_W    = ADDR_W - OFFSET_BITS;
  localparam int FRAME_W  = 6;
  localparam int DISK_W   = 7;
  localparam int STATUS_W = 3;
  localparam int SIZE_W   = 17;
  localparam int CNT_W    = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_ACCESS = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT_CLEAN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT_DIRTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [5:0]         page_index;
    logic [FRAME_W-1:0] load_frame;
    logic [DISK_W-1:0]  load_disk_block;
    logic               load_resident;
    logic [ADDR_W-1:0]  logical_address;
    logic               is_write;
  } ptfr_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ADDR_W-1:0]      physical_address;
    logic [PNO_W-1:0]       page_number;
    logic [OFFSET_BITS-1:0] page_offset;
    logic [5:0]             evicted_page;
    logic [FRAME_W-1:0]     frame_used;
    logic [DISK_W-1:0]      writeback_disk_block;
    logic [DISK_W-1:0]      fetch_disk_block;
    logic [CNT_W-1:0]       access_total;
    logic [CNT_W-1:0]       fault_total;
  } ptfr_out_t;

  // One page table entry
  typedef struct packed {
    logic               resident;
    logic               modified;
    logic [FRAME_W-1:0] frame;
    logic [DISK_W-1:0]  disk;
  } ptfr_entry_t;

endpackage

>>> src/paged_translation_fifo_replace.sv
// Page table translation with FIFO replacement. Depends on ptfr_pkg.
// out_valid is registered from exec_r, which the accepting edge sets. The receiver
//   cannot stall.
// No new request is taken while busy. busy is high for the cycle after each
//   accepted request, while it executes; a second table write lands once busy falls.
// Reset (rst_n, synchronous, active low) clears FIFO pointers, counters and size.
module paged_translation_fifo_replace
  import ptfr_pkg::*;
#(
  parameter int PAGES = MAX_PAGES,
  parameter int SLOTS = RESIDENT_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptfr_in_t          in_item,
  output logic              out_valid,
  output ptfr_out_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int PG_W   = $clog2(PAGES);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SLOTS);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Control and state registers
  logic              exec_r;
  logic              out_valid_r;
  ptfr_in_t          in_r;
  ptfr_out_t         out_item_r;
  logic [SIZE_W-1:0] process_size_r;
  logic [CNT_W-1:0]  acc_cnt_r, acc_cnt_nxt;
  logic [CNT_W-1:0]  flt_cnt_r, flt_cnt_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PG_W-1:0]   fifo_pages_r [SLOTS];
  logic              fifo_we;
  logic [PG_W-1:0]   fifo_wpage;

  // Page table memory and its pending second write
  ptfr_entry_t       tbl_mem [PAGES];
  ptfr_entry_t       rd_tgt_r, rd_vic_r;
  logic              fwd_tgt_r, fwd_vic_r;
  logic              pend_vld_r;
  logic [PG_W-1:0]   pend_addr_r;
  ptfr_entry_t       pend_data_r;
  logic              pend_we;
  logic [PG_W-1:0]   pend_addr;
  ptfr_entry_t       pend_data;
  logic              vic_we;
  ptfr_entry_t       vic_wdata;
  logic              mem_we;
  logic [PG_W-1:0]   mem_waddr;
  ptfr_entry_t       mem_wdata;
  logic [PG_W-1:0]   rd_addr_tgt, rd_addr_vic;

  logic              accept;
  ptfr_out_t         rsp;
  ptfr_entry_t       tgt_ent, vic_ent;
  logic [PNO_W-1:0]  pno;
  logic [PG_W-1:0]   tgt_page, vic_page;
  logic [FRAME_W-1:0] fused;
  logic              in_range;

  assign accept    = start & ~exec_r;
  assign busy      = exec_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Read addresses: target page from the incoming request, victim from FIFO head
  assign rd_addr_tgt = PG_W'(in_item.logical_address[ADDR_W-1:OFFSET_BITS]);
  assign rd_addr_vic = fifo_pages_r[head_r];

  // Single write port: victim clear during execute, pending write the cycle after
  assign mem_we    = vic_we | pend_vld_r;
  assign mem_waddr = vic_we ? vic_page : pend_addr_r;
  assign mem_wdata = vic_we ? vic_wdata : pend_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rd_tgt_r <= tbl_mem[rd_addr_tgt];
    rd_vic_r <= tbl_mem[rd_addr_vic];
  end

  // Forward the pending write over stale read data
  assign tgt_ent = fwd_tgt_r ? pend_data_r : rd_tgt_r;
  assign vic_ent = fwd_vic_r ? pend_data_r : rd_vic_r;

  assign pno      = in_r.logical_address[ADDR_W-1:OFFSET_BITS];
  assign tgt_page = PG_W'(pno);
  assign vic_page = fifo_pages_r[head_r];
  assign in_range = ({1'b0, in_r.logical_address} < process_size_r) &&
                    (int'(pno) < PAGES);

  // Execute one request
  always_comb begin
    rsp         = '0;
    rsp.status  = ST_DONE;
    acc_cnt_nxt = acc_cnt_r;
    flt_cnt_nxt = flt_cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    fifo_we     = 1'b0;
    fifo_wpage  = tgt_page;
    pend_we     = 1'b0;
    pend_addr   = tgt_page;
    pend_data   = tgt_ent;
    vic_we      = 1'b0;
    vic_wdata   = vic_ent;
    fused       = '0;
    if (exec_r) begin
      case (in_r.opcode)
        OP_CLEAR: begin
          head_nxt    = '0;
          tail_nxt    = '0;
          fill_nxt    = '0;
          acc_cnt_nxt = '0;
          flt_cnt_nxt = '0;
        end
        OP_LOAD: begin
          if (int'(in_r.page_index) < PAGES && int'(in_r.load_frame) < FRAME_COUNT &&
              int'(in_r.load_disk_block) < DISK_BLOCKS) begin
            pend_we            = 1'b1;
            pend_addr          = PG_W'(in_r.page_index);
            pend_data.resident = in_r.load_resident;
            pend_data.modified = 1'b0;
            pend_data.frame    = in_r.load_frame;
            pend_data.disk     = in_r.load_disk_block;
            // Append a resident page, dropping the oldest when full
            if (in_r.load_resident) begin
              fifo_we    = 1'b1;
              fifo_wpage = PG_W'(in_r.page_index);
              tail_nxt   = next_slot(tail_r);
              if (fill_r >= FULL_FILL) begin
                head_nxt = next_slot(tail_r);
              end else begin
                fill_nxt = fill_r + 1'b1;
              end
            end
          end
        end
        OP_ACCESS: begin
          rsp.page_number = pno;
          rsp.page_offset = in_r.logical_address[OFFSET_BITS-1:0];
          if (!in_range) begin
            rsp.status = ST_OUT_RANGE;
          end else begin
            acc_cnt_nxt = sat_inc(acc_cnt_r);
            if (tgt_ent.resident) begin
              rsp.status = ST_HIT;
              fused      = tgt_ent.frame;
              if (in_r.is_write) begin
                pend_we            = 1'b1;
                pend_data.modified = 1'b1;
              end
            end else begin
              flt_cnt_nxt          = sat_inc(flt_cnt_r);
              rsp.fetch_disk_block = tgt_ent.disk;
              if (fill_r == '0) begin
                rsp.status = ST_NO_FRAME;
              end else begin
                // Evict the head, reuse its frame, requeue the new page
                rsp.evicted_page = 6'(vic_page);
                if (vic_ent.modified) begin
                  rsp.status               = ST_FAULT_DIRTY;
                  rsp.writeback_disk_block = vic_ent.disk;
                end else begin
                  rsp.status = ST_FAULT_CLEAN;
                end
                vic_we             = (vic_page != tgt_page);
                vic_wdata.resident = 1'b0;
                vic_wdata.modified = 1'b0;
                pend_we            = 1'b1;
                pend_data.resident = 1'b1;
                pend_data.modified = in_r.is_write;
                pend_data.frame    = vic_ent.frame;
                fused              = vic_ent.frame;
                fifo_we            = 1'b1;
                head_nxt           = next_slot(head_r);
                tail_nxt           = next_slot(tail_r);
              end
            end
            if (rsp.status == ST_HIT || rsp.status == ST_FAULT_CLEAN ||
                rsp.status == ST_FAULT_DIRTY) begin
              rsp.physical_address = {fused, in_r.logical_address[OFFSET_BITS-1:0]};
            end
          end
        end
        default: begin
          rsp.status = ST_DONE;
        end
      endcase
    end
    rsp.frame_used   = fused;
    rsp.access_total = acc_cnt_nxt;
    rsp.fault_total  = flt_cnt_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      pend_vld_r     <= 1'b0;
      fwd_tgt_r      <= 1'b0;
      fwd_vic_r      <= 1'b0;
      process_size_r <= '0;
      acc_cnt_r      <= '0;
      flt_cnt_r      <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      fill_r         <= '0;
    end else begin
      exec_r      <= accept;
      out_valid_r <= exec_r;
      pend_vld_r  <= pend_we;
      fwd_tgt_r   <= pend_vld_r && (pend_addr_r == rd_addr_tgt);
      fwd_vic_r   <= pend_vld_r && (pend_addr_r == rd_addr_vic);
      if (cfg_valid && cfg_ready) begin
        process_size_r <= cfg_data;
      end
      acc_cnt_r <= acc_cnt_nxt;
      flt_cnt_r <= flt_cnt_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
    if (exec_r) begin
      out_item_r <= rsp;
    end
    if (pend_we) begin
      pend_addr_r <= pend_addr;
      pend_data_r <= pend_data;
    end
    if (fifo_we) begin
      fifo_pages_r[tail_r] <= fifo_wpage;
    end
  end

endmodule

>>> src/ptfr_check.sv
// Port-level checks for paged_translation_fifo_replace, bound to the top level.
// Depends on ptfr_pkg.
module ptfr_check
  import ptfr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input ptfr_out_t out_item
);

  // An accepted request makes the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Busy lasts one cycle and is followed by a result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("busy not followed by a single result");

  // A result is shown only while idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Faults are a subset of accesses
  a_fault_le_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.fault_total <= out_item.access_total))
    else $error("fault total above access total");

  // Setup requests carry no translation
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_DONE) |->
      (out_item.physical_address == '0 && out_item.evicted_page == '0))
    else $error("done status with translation fields set");

endmodule

bind paged_translation_fifo_replace ptfr_check u_ptfr_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
